/* hdl/pps_pkg.sv */
`default_nettype none

package pps_pkg;

	localparam int unsigned SLOTS_DEF  = 16;
	localparam int unsigned TIME_W     = 16;
	localparam int unsigned PRIO_W     = 8;
	localparam int unsigned SLOT_OUT_W = 4;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

	// item function codes
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	typedef struct packed {
		logic              func;
		logic [TIME_W-1:0] arrival_time;
		logic [TIME_W-1:0] burst_length;
		logic [PRIO_W-1:0] priority_level;
	} task_item_t;

	typedef struct packed {
		logic                  ran_valid;
		logic [SLOT_OUT_W-1:0] ran_slot;
		logic [TIME_W-1:0]     tick_time;
		logic                  finished;
		logic [TIME_W-1:0]     turnaround_time;
		logic [TIME_W-1:0]     waiting_time;
		logic [TIME_W-1:0]     response_time;
	} res_item_t;

	// one slot of the task table
	typedef struct packed {
		logic [TIME_W-1:0] arrival;
		logic [PRIO_W-1:0] prio;
		logic [TIME_W-1:0] burst;
		logic [TIME_W-1:0] remaining;
		logic [TIME_W-1:0] first_run;
	} slot_rec_t;

endpackage

`default_nettype wire

/* hdl/pps_if.sv */
`default_nettype none

interface pps_task_if;
	logic                 valid;
	logic                 ready;
	pps_pkg::task_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

interface pps_res_if;
	logic                valid;
	logic                ready;
	pps_pkg::res_item_t  item;

	modport source (output valid, output item, input ready);
	modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

/* hdl/priority_preemptive_scheduler.sv */
// preemptive priority scheduler over a table of task slots
//
// channels: tasks (sink) carries load and tick items, results (source) carries
// one result item per tick item; a load item produces no result
// a load writes the next free slot; loads beyond SLOTS are dropped
// a tick reads the slot table one entry per cycle from a synchronous memory,
// keeps the lowest priority eligible slot (lower slot wins ties), then writes
// back the served slot and pushes the result
// after a tick is accepted, tasks.ready stays low for one read per loaded slot,
// the read register stage, draining the last compare and the update step, which
// waits for a free output register; the result enters the output register at
// the same edge at which tasks.ready returns
// stall: the output register holds a result until results.ready; new items
// are still accepted meanwhile, and a following tick waits in its update step
// reset: arst_n clears the slot count, the time counter, the started flags and
// the output valid flag; slot contents need no clearing
// time saturates at its maximum
`default_nettype none

module priority_preemptive_scheduler #(
	parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	pps_task_if.sink  tasks,
	pps_res_if.source results
);
	import pps_pkg::*;

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);

	logic              res_push;
	logic              res_ready;
	res_item_t         res_item;
	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	slot_rec_t         mem_wdata;
	logic              mem_re;
	logic [IDX_W-1:0]  mem_raddr;
	slot_rec_t         mem_rdata;

	logic              out_valid_q;
	res_item_t         out_item_q;

	// output register is free when empty or being drained this cycle
	assign res_ready = !out_valid_q || results.ready;

	pps_core #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W),
		.CNT_W(CNT_W)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (tasks.valid),
		.in_ready  (tasks.ready),
		.in_item   (tasks.item),
		.res_push  (res_push),
		.res_ready (res_ready),
		.res_item  (res_item),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// slot table; writes and reads of one tick never overlap on the same cycle
	pps_mem #(
		.SLOTS(SLOTS),
		.IDX_W(IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_push) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_push) begin
			out_item_q <= res_item;
		end
	end

	assign results.valid = out_valid_q;
	assign results.item  = out_item_q;

endmodule

`default_nettype wire

/* hdl/pps_mem.sv */
`default_nettype none

module pps_mem #(
	parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF,
	parameter int unsigned IDX_W = $clog2(SLOTS)
) (
	input  wire logic               clk,
	input  wire logic               we,
	input  wire logic [IDX_W-1:0]   waddr,
	input  wire pps_pkg::slot_rec_t wdata,
	input  wire logic               re,
	input  wire logic [IDX_W-1:0]   raddr,
	output pps_pkg::slot_rec_t      rdata
);
	import pps_pkg::*;

	slot_rec_t mem_q [SLOTS];
	slot_rec_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* hdl/pps_core.sv */
`default_nettype none

module pps_core #(
	parameter int unsigned SLOTS = pps_pkg::SLOTS_DEF,
	parameter int unsigned IDX_W = $clog2(SLOTS),
	parameter int unsigned CNT_W = $clog2(SLOTS + 1)
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire pps_pkg::task_item_t in_item,
	output logic                     res_push,
	input  wire logic                res_ready,
	output pps_pkg::res_item_t       res_item,
	output logic                     mem_we,
	output logic [IDX_W-1:0]         mem_waddr,
	output pps_pkg::slot_rec_t       mem_wdata,
	output logic                     mem_re,
	output logic [IDX_W-1:0]         mem_raddr,
	input  wire pps_pkg::slot_rec_t  mem_rdata
);
	import pps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_UPD  = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   loaded_q;
	logic [TIME_W-1:0]  time_q;
	logic [CNT_W-1:0]   rd_idx_q;
	logic               chk_valid_s1;
	logic               found_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [IDX_W-1:0]   chk_idx_s1;
	slot_rec_t          best_q;
	logic [SLOTS-1:0]   started_q;

	logic               accept;
	logic               load_ok;
	logic               tick_go;
	logic               take;
	logic               upd_fire;
	logic [TIME_W-1:0]  done_time;
	logic [TIME_W-1:0]  rem_new;
	logic [TIME_W-1:0]  first_run;
	logic [TIME_W-1:0]  turn;
	logic [TIME_W-1:0]  wait_t;
	logic [TIME_W-1:0]  resp;
	logic               fin;
	logic [SLOT_OUT_W+IDX_W-1:0] slot_ext;
	slot_rec_t          load_rec;
	slot_rec_t          upd_rec;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_ok  = accept && (in_item.func == FUNC_LOAD) && (loaded_q < CNT_W'(SLOTS));
	assign tick_go  = accept && (in_item.func == FUNC_TICK);

	// scan: one table read per cycle, compare in the cycle after the read
	assign mem_re    = (state_q == ST_SCAN) && (rd_idx_q != loaded_q);
	assign mem_raddr = rd_idx_q[IDX_W-1:0];

	assign take = chk_valid_s1 && (mem_rdata.remaining != '0)
		&& (mem_rdata.arrival <= time_q)
		&& (!found_q || (mem_rdata.prio < best_q.prio));

	// update of the chosen slot
	assign upd_fire  = (state_q == ST_UPD) && res_ready;
	assign done_time = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
	assign rem_new   = best_q.remaining - TIME_W'(1);
	assign fin       = (rem_new == '0);
	assign first_run = started_q[best_idx_q] ? best_q.first_run : time_q;
	assign turn      = done_time - best_q.arrival;
	assign wait_t    = (turn >= best_q.burst) ? turn - best_q.burst : '0;
	assign resp      = first_run - best_q.arrival;
	assign slot_ext  = {SLOT_OUT_W'(0), best_idx_q};

	always_comb begin
		load_rec           = '0;
		load_rec.arrival   = in_item.arrival_time;
		load_rec.prio      = in_item.priority_level;
		load_rec.burst     = in_item.burst_length;
		load_rec.remaining = in_item.burst_length;

		upd_rec           = best_q;
		upd_rec.remaining = rem_new;
		upd_rec.first_run = first_run;
	end

	always_comb begin
		mem_we    = load_ok || (upd_fire && found_q);
		mem_waddr = upd_fire ? best_idx_q : loaded_q[IDX_W-1:0];
		mem_wdata = upd_fire ? upd_rec : load_rec;
	end

	always_comb begin
		res_push           = upd_fire;
		res_item           = '0;
		res_item.tick_time = time_q;
		if (found_q) begin
			res_item.ran_valid = 1'b1;
			res_item.ran_slot  = slot_ext[SLOT_OUT_W-1:0];
			if (fin) begin
				res_item.finished        = 1'b1;
				res_item.turnaround_time = turn;
				res_item.waiting_time    = wait_t;
				res_item.response_time   = resp;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			loaded_q     <= '0;
			time_q       <= '0;
			rd_idx_q     <= '0;
			chk_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			started_q    <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (load_ok) begin
						started_q[loaded_q[IDX_W-1:0]] <= 1'b0;
						loaded_q <= loaded_q + CNT_W'(1);
					end
					if (tick_go) begin
						state_q      <= ST_SCAN;
						rd_idx_q     <= '0;
						chk_valid_s1 <= 1'b0;
						found_q      <= 1'b0;
					end
				end
				ST_SCAN: begin
					chk_valid_s1 <= mem_re;
					if (mem_re) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (take) begin
						found_q <= 1'b1;
					end
					if ((rd_idx_q == loaded_q) && !chk_valid_s1) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					if (upd_fire) begin
						time_q  <= done_time;
						state_q <= ST_IDLE;
						if (found_q) begin
							started_q[best_idx_q] <= 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload of the scan, no reset needed
	always_ff @(posedge clk) begin
		if (mem_re) begin
			chk_idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (take) begin
			best_q     <= mem_rdata;
			best_idx_q <= chk_idx_s1;
		end
	end

endmodule

`default_nettype wire

/* hdl/pps_checker.sv */
`default_nettype none

module pps_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                task_valid,
	input wire logic                task_ready,
	input wire pps_pkg::task_item_t task_item,
	input wire logic                res_valid,
	input wire logic                res_ready,
	input wire pps_pkg::res_item_t  res_item
);
	import pps_pkg::*;

	// a pending result stays until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_item))
		else $error("result dropped or changed while stalled");

	// a tick blocks the input while the table is scanned
	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		task_valid && task_ready && (task_item.func == FUNC_TICK) |=> !task_ready)
		else $error("input ready right after a tick");

	// completion only for a served task
	a_fin_served: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.finished |-> res_item.ran_valid)
		else $error("finished without a served task");

	// idle tick reports nothing but time
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_item.ran_valid |->
			(res_item.ran_slot == '0) && (res_item.turnaround_time == '0))
		else $error("idle tick carries slot data");

	// waiting never exceeds turnaround
	a_wait_le_turn: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.finished |->
			res_item.waiting_time <= res_item.turnaround_time)
		else $error("waiting time above turnaround time");

endmodule

bind priority_preemptive_scheduler pps_checker u_pps_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.task_valid (tasks.valid),
	.task_ready (tasks.ready),
	.task_item  (tasks.item),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_item   (results.item)
);

`default_nettype wire
